/* rtl/core/skvt_pkg.sv */
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants of the sorted key-value table: operation and
// status codes, controller states, and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_FIND   = 2'd1,
    FUNC_DELETE = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED  = 3'd0,
    STS_UPDATED   = 3'd1,
    STS_FOUND     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_DELETED   = 3'd4,
    STS_FULL      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_SRCH_CMP,
    S_DECIDE,
    S_UP,
    S_UP_WR,
    S_DN,
    S_DN_WR
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SRCH_RD,
    OP_SRCH_CMP,
    OP_UPDATE,
    OP_UP_INIT,
    OP_UP_RD,
    OP_UP_WR,
    OP_INS_NEW,
    OP_DN_INIT,
    OP_DN_RD,
    OP_DN_WR,
    OP_DEL_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    resp;
    status_e status;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  hit;
    logic  full;
    logic  srch_done;
    logic  up_done;
    logic  dn_done;
    logic  out_free;
  } sts_t;

endpackage

/* rtl/core/skvt_ctrl.sv */
// ----------------------------------------------------------------------------
// skvt_ctrl
// Request sequencer: binary search for the lower bound, then update, shift
// up for an insert, or shift down for a delete, and hand the result to the
// output register when it is free.
// ----------------------------------------------------------------------------
module skvt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  skvt_pkg::sts_t sts_i,
  output skvt_pkg::cmd_t cmd_o
);
  import skvt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SRCH;
      end
      S_SRCH: begin
        state_d = sts_i.srch_done ? S_DECIDE : S_SRCH_CMP;
      end
      S_SRCH_CMP: state_d = S_SRCH;
      S_DECIDE: begin
        if (sts_i.func == FUNC_INSERT && !sts_i.hit && !sts_i.full) begin
          state_d = S_UP;
        end else if (sts_i.func == FUNC_DELETE && sts_i.hit) begin
          state_d = S_DN;
        end else if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_UP: begin
        if (!sts_i.up_done) begin
          state_d = S_UP_WR;
        end else if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_UP_WR: state_d = S_UP;
      S_DN: begin
        if (!sts_i.dn_done) begin
          state_d = S_DN_WR;
        end else if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DN_WR: state_d = S_DN;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '{op: OP_NONE, resp: 1'b0, status: STS_NOT_FOUND};
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_SRCH: begin
        if (!sts_i.srch_done) cmd_o.op = OP_SRCH_RD;
      end
      S_SRCH_CMP: cmd_o.op = OP_SRCH_CMP;
      S_DECIDE: begin
        unique case (sts_i.func)
          FUNC_INSERT: begin
            if (sts_i.hit) begin
              if (sts_i.out_free) begin
                cmd_o.op     = OP_UPDATE;
                cmd_o.resp   = 1'b1;
                cmd_o.status = STS_UPDATED;
              end
            end else if (sts_i.full) begin
              if (sts_i.out_free) begin
                cmd_o.resp   = 1'b1;
                cmd_o.status = STS_FULL;
              end
            end else begin
              cmd_o.op = OP_UP_INIT;
            end
          end
          FUNC_FIND: begin
            if (sts_i.out_free) begin
              cmd_o.resp   = 1'b1;
              cmd_o.status = sts_i.hit ? STS_FOUND : STS_NOT_FOUND;
            end
          end
          FUNC_DELETE: begin
            if (sts_i.hit) begin
              cmd_o.op = OP_DN_INIT;
            end else if (sts_i.out_free) begin
              cmd_o.resp   = 1'b1;
              cmd_o.status = STS_NOT_FOUND;
            end
          end
          default: begin
            if (sts_i.out_free) begin
              cmd_o.resp   = 1'b1;
              cmd_o.status = STS_NOT_FOUND;
            end
          end
        endcase
      end
      S_UP: begin
        if (!sts_i.up_done) begin
          cmd_o.op = OP_UP_RD;
        end else if (sts_i.out_free) begin
          cmd_o.op     = OP_INS_NEW;
          cmd_o.resp   = 1'b1;
          cmd_o.status = STS_INSERTED;
        end
      end
      S_UP_WR: cmd_o.op = OP_UP_WR;
      S_DN: begin
        if (!sts_i.dn_done) begin
          cmd_o.op = OP_DN_RD;
        end else if (sts_i.out_free) begin
          cmd_o.op     = OP_DEL_FIN;
          cmd_o.resp   = 1'b1;
          cmd_o.status = STS_DELETED;
        end
      end
      S_DN_WR: cmd_o.op = OP_DN_WR;
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

/* rtl/core/skvt_dp.sv */
// ----------------------------------------------------------------------------
// skvt_dp
// Datapath: entry memory with one write and one registered read port,
// search bounds, move pointer, live count, request registers and the
// output register.
// ----------------------------------------------------------------------------
module skvt_dp #(
  parameter int unsigned CAPACITY    = skvt_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = skvt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  skvt_pkg::cmd_t                      cmd_i,
  output skvt_pkg::sts_t                      sts_o,
  input  logic [skvt_pkg::FUNC_W-1:0]         func_i,
  input  logic signed [skvt_pkg::KEY_W-1:0]   key_i,
  input  logic [skvt_pkg::DATA_W-1:0]         value_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [skvt_pkg::STATUS_W-1:0]       status_o,
  output logic [skvt_pkg::DATA_W-1:0]         value_out_o
);
  import skvt_pkg::*;

  localparam int unsigned IDX_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned ENTRY_W = KEY_W + VALUE_WIDTH;

  logic [ENTRY_W-1:0] mem_q [CAPACITY];
  logic [ENTRY_W-1:0] rd_data_q;
  logic [ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic               rd_en, wr_en;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, ptr_q, ptr_d;
  logic [IDX_W-1:0] mid_q, mid;
  logic [CNT_W:0]   mid_sum, ptr_inc;
  logic             hit_q, hit_d;

  logic [VALUE_WIDTH-1:0]  hit_val_q, hit_val_d;
  logic [FUNC_W-1:0]       func_q;
  logic signed [KEY_W-1:0] key_q, rd_key;
  logic [VALUE_WIDTH-1:0]  val_q, rd_val;

  logic                out_valid_q, out_valid_d, out_free;
  logic [STATUS_W-1:0] out_status_q;
  logic [DATA_W-1:0]   out_value_q, resp_value;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IDX_W:1];
  assign ptr_inc = {1'b0, ptr_q} + (CNT_W + 1)'(1);
  assign rd_key  = $signed(rd_data_q[ENTRY_W-1 -: KEY_W]);
  assign rd_val  = rd_data_q[VALUE_WIDTH-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.func      = func_e'(func_q);
    sts_o.hit       = hit_q;
    sts_o.full      = (count_q == CNT_W'(CAPACITY));
    sts_o.srch_done = (lo_q == hi_q);
    sts_o.up_done   = (ptr_q == lo_q);
    sts_o.dn_done   = (ptr_inc >= {1'b0, count_q});
    sts_o.out_free  = out_free;
  end

  always_comb begin
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    ptr_d     = ptr_q;
    hit_d     = hit_q;
    hit_val_d = hit_val_q;
    rd_en     = 1'b0;
    rd_addr   = mid;
    wr_en     = 1'b0;
    wr_addr   = ptr_q[IDX_W-1:0];
    wr_data   = rd_data_q;
    unique case (cmd_i.op)
      OP_NONE: ;
      OP_LOAD: begin
        lo_d  = '0;
        hi_d  = count_q;
        hit_d = 1'b0;
      end
      OP_SRCH_RD: rd_en = 1'b1;
      OP_SRCH_CMP: begin
        if (rd_key < key_q) begin
          lo_d = CNT_W'(mid_q) + CNT_W'(1);
        end else begin
          hi_d = CNT_W'(mid_q);
        end
        // keys are unique, so an equal probe is the lower bound itself
        if (rd_key == key_q) begin
          hit_d     = 1'b1;
          hit_val_d = rd_val;
        end
      end
      OP_UPDATE: begin
        wr_en   = 1'b1;
        wr_addr = lo_q[IDX_W-1:0];
        wr_data = {key_q, val_q};
      end
      OP_UP_INIT: ptr_d = count_q;
      OP_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr_d[IDX_W-1:0] - IDX_W'(1);
      end
      OP_UP_WR: begin
        wr_en = 1'b1;
        ptr_d = ptr_q - CNT_W'(1);
      end
      OP_INS_NEW: begin
        wr_en   = 1'b1;
        wr_data = {key_q, val_q};
        count_d = count_q + CNT_W'(1);
      end
      OP_DN_INIT: ptr_d = lo_q;
      OP_DN_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr_inc[IDX_W-1:0];
      end
      OP_DN_WR: begin
        wr_en = 1'b1;
        ptr_d = ptr_inc[CNT_W-1:0];
      end
      OP_DEL_FIN: count_d = count_q - CNT_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      ptr_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      ptr_q   <= ptr_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_val_q <= hit_val_d;
    if (cmd_i.op == OP_SRCH_RD) mid_q <= mid;
    if (cmd_i.op == OP_LOAD) begin
      func_q <= func_i;
      key_q  <= key_i;
      val_q  <= VALUE_WIDTH'(value_i);
    end
  end

  // response value: new value on update, stored value on find, else zero
  always_comb begin
    unique case (cmd_i.status)
      STS_UPDATED: resp_value = DATA_W'(val_q);
      STS_FOUND:   resp_value = DATA_W'(hit_val_q);
      default:     resp_value = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.resp) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      out_status_q <= cmd_i.status;
      out_value_q  <= resp_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_out_o = out_value_q;

endmodule

/* rtl/core/sorted_key_value_table_top.sv */
// ----------------------------------------------------------------------------
// sorted_key_value_table_top
// Key-value table kept in ascending signed key order with insert/update,
// find and delete requests; one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o, func_i, key_i, value_i) and
//   result channel (out_valid_o / out_stall_i, status_o, value_out_o); a
//   transfer happens at a clock edge with valid high and stall low.
//   One request is worked at a time; in_stall_o is high from the transfer
//   until the result is loaded into the output register.
//   A binary search takes up to ceil(log2(count+1)) steps, each a memory
//   read, then a compare. An insert of a new key then moves the entries
//   above the slot up; a delete that hits moves the entries above the
//   slot down. Each moved entry takes one read and one write on the
//   single entry memory. The next request can transfer in the cycle
//   after the result is loaded.
//   A waiting result sits in the output register while the next request
//   is taken; a stalled result holds and the next result waits behind it.
//   Reset empties the table (live count zero); no memory sweep is needed.
// ----------------------------------------------------------------------------
module sorted_key_value_table_top #(
  parameter int unsigned CAPACITY    = skvt_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = skvt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [skvt_pkg::FUNC_W-1:0]       func_i,
  input  logic signed [skvt_pkg::KEY_W-1:0] key_i,
  input  logic [skvt_pkg::DATA_W-1:0]       value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [skvt_pkg::STATUS_W-1:0]     status_o,
  output logic [skvt_pkg::DATA_W-1:0]       value_out_o
);
  import skvt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  skvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  skvt_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .func_i      (func_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .value_out_o (value_out_o)
  );

endmodule

/* rtl/core/skvt_chk.sv */
// ----------------------------------------------------------------------------
// skvt_chk
// Port-level checks of the sorted key-value table, bound to the top level.
// ----------------------------------------------------------------------------
module skvt_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [skvt_pkg::STATUS_W-1:0]     status_o,
  input logic [skvt_pkg::DATA_W-1:0]       value_out_o
);
  import skvt_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(value_out_o))
    else $error("stalled result changed");

  // one request at a time: a transfer closes the request channel
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in work");

  // a new result only comes from a request in work
  a_result_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in work");

  // value is carried only on found and updated
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STS_FOUND && status_o != STS_UPDATED |-> value_out_o == '0)
    else $error("nonzero value on a status without value");

endmodule

bind sorted_key_value_table_top skvt_chk u_skvt_chk (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted key-value table. A table of directed
// requests covers the key extremes, every operation and the empty, missing
// and unused-code cases. Random phases then fill the table past capacity,
// mix operations on a shared key pool, and drain it again. A shadow table
// predicts each result that no directed row fixes; all are compared in order.
// ----------------------------------------------------------------------------
module tb;
  import skvt_pkg::*;

  localparam int unsigned TABLE_DEPTH    = CAPACITY_DEF;
  localparam int unsigned POOL_SIZE      = 70;
  localparam int unsigned N_DIRECTED     = 23;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 200;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_BURST
  } stall_mode_e;

  typedef struct packed {
    status_e            status;
    logic [DATA_W-1:0]  value;
  } table_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  value;
    logic               known;
    status_e            status;
    logic [DATA_W-1:0]  value_out;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [FUNC_W-1:0]        func_i;
  logic signed [KEY_W-1:0]  key_i;
  logic [DATA_W-1:0]        value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [STATUS_W-1:0]      status_o;
  logic [DATA_W-1:0]        value_out_o;

  // Shadow of the table contents, kept in ascending key order.
  logic signed [KEY_W-1:0]  shadow_keys [TABLE_DEPTH];
  logic [DATA_W-1:0]        shadow_values [TABLE_DEPTH];
  int unsigned              shadow_count = 0;

  table_result_t            pending_results [$];
  logic [KEY_W-1:0]         key_pool [POOL_SIZE];

  int unsigned              burst_left = 0;
  int unsigned              requests_sent = 0;
  int unsigned              results_checked = 0;
  int unsigned              error_count = 0;
  int unsigned              status_hits [6] = '{default: 0};
  int unsigned              stall_cycle = 0;
  stall_mode_e              stall_mode = STALL_NONE;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{FUNC_FIND,   32'h0000_0000, 32'h0000_0000, 1'b1, STS_NOT_FOUND, 32'h0000_0000},
    '{FUNC_DELETE, 32'h0000_0005, 32'h0000_0000, 1'b1, STS_NOT_FOUND, 32'h0000_0000},
    '{FUNC_UNUSED, 32'h0000_0000, 32'hffff_ffff, 1'b1, STS_NOT_FOUND, 32'h0000_0000},
    '{FUNC_INSERT, 32'h8000_0000, 32'hffff_ffff, 1'b1, STS_INSERTED,  32'h0000_0000},
    '{FUNC_INSERT, 32'h7fff_ffff, 32'h0000_0000, 1'b1, STS_INSERTED,  32'h0000_0000},
    '{FUNC_INSERT, 32'h8000_0002, 32'ha5a5_a5a5, 1'b1, STS_INSERTED,  32'h0000_0000},
    '{FUNC_INSERT, 32'h7fff_fffe, 32'h5a5a_5a5a, 1'b1, STS_INSERTED,  32'h0000_0000},
    '{FUNC_INSERT, 32'h0000_0000, 32'h0000_0001, 1'b1, STS_INSERTED,  32'h0000_0000},
    '{FUNC_FIND,   32'h8000_0000, 32'h0000_0000, 1'b1, STS_FOUND,     32'hffff_ffff},
    '{FUNC_FIND,   32'h7fff_ffff, 32'h1234_0000, 1'b1, STS_FOUND,     32'h0000_0000},
    '{FUNC_INSERT, 32'h0000_0000, 32'hdead_beef, 1'b1, STS_UPDATED,   32'hdead_beef},
    '{FUNC_FIND,   32'h0000_0000, 32'h0000_0000, 1'b1, STS_FOUND,     32'hdead_beef},
    '{FUNC_FIND,   32'hffff_ffff, 32'h0000_0000, 1'b1, STS_NOT_FOUND, 32'h0000_0000},
    '{FUNC_UNUSED, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, STS_NOT_FOUND, 32'h0000_0000},
    '{FUNC_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, STS_DELETED,   32'h0000_0000},
    '{FUNC_FIND,   32'h0000_0000, 32'h0000_0000, 1'b1, STS_NOT_FOUND, 32'h0000_0000},
    '{FUNC_DELETE, 32'h8000_0000, 32'h0000_0000, 1'b1, STS_DELETED,   32'h0000_0000},
    '{FUNC_FIND,   32'h8000_0002, 32'h0000_0000, 1'b0, STS_NOT_FOUND, 32'h0000_0000},
    '{FUNC_INSERT, 32'hffff_ffff, 32'h1234_5678, 1'b0, STS_NOT_FOUND, 32'h0000_0000},
    '{FUNC_INSERT, 32'h8000_0001, 32'h0000_ffff, 1'b0, STS_NOT_FOUND, 32'h0000_0000},
    '{FUNC_FIND,   32'h7fff_fffe, 32'h0000_0000, 1'b0, STS_NOT_FOUND, 32'h0000_0000},
    '{FUNC_DELETE, 32'h7fff_ffff, 32'h0000_0000, 1'b0, STS_NOT_FOUND, 32'h0000_0000},
    '{FUNC_FIND,   32'h7fff_ffff, 32'h0000_0000, 1'b1, STS_NOT_FOUND, 32'h0000_0000}
  };

  sorted_key_value_table_top #(
    .CAPACITY    (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH_DEF)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .value_out_o (value_out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one request to the shadow table and return the result it gives.
  function automatic table_result_t predict_table_op(logic [FUNC_W-1:0] op,
                                                     logic signed [KEY_W-1:0] k,
                                                     logic [DATA_W-1:0] v);
    table_result_t r;
    int unsigned   pos;
    int unsigned   j;
    logic          hit;
    r.status = STS_NOT_FOUND;
    r.value  = '0;
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] < k) pos++;
    hit = (pos < shadow_count) && (shadow_keys[pos] == k);
    case (op)
      FUNC_INSERT: begin
        if (hit) begin
          shadow_values[pos] = v;
          r.status = STS_UPDATED;
          r.value  = v;
        end else if (shadow_count >= TABLE_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          for (j = shadow_count; j > pos; j--) begin
            shadow_keys[j]   = shadow_keys[j-1];
            shadow_values[j] = shadow_values[j-1];
          end
          shadow_keys[pos]   = k;
          shadow_values[pos] = v;
          shadow_count++;
          r.status = STS_INSERTED;
        end
      end
      FUNC_FIND: begin
        if (hit) begin
          r.status = STS_FOUND;
          r.value  = shadow_values[pos];
        end
      end
      FUNC_DELETE: begin
        if (hit) begin
          for (j = pos; j + 1 < shadow_count; j++) begin
            shadow_keys[j]   = shadow_keys[j+1];
            shadow_values[j] = shadow_values[j+1];
          end
          shadow_count--;
          r.status = STS_DELETED;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Drive one request, hold it until the transfer, then record its result.
  task automatic push_request(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
                              input logic [DATA_W-1:0] v, input bit fixed = 1'b0,
                              input table_result_t fixed_res = '0);
    table_result_t predicted;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    key_i      <= k;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    burst_left--;
    predicted = predict_table_op(op, k, v);
    pending_results.push_back(fixed ? fixed_res : predicted);
    requests_sent++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Weighted random operation, mostly on pool keys so that hits are common.
  task automatic push_pool_op(input int unsigned ins_w, input int unsigned find_w,
                              input int unsigned del_w);
    int unsigned       pick;
    logic [FUNC_W-1:0] op;
    logic [KEY_W-1:0]  k;
    pick = $urandom_range(0, 99);
    if (pick < ins_w)                      op = FUNC_INSERT;
    else if (pick < ins_w + find_w)        op = FUNC_FIND;
    else if (pick < ins_w + find_w + del_w) op = FUNC_DELETE;
    else                                   op = FUNC_UNUSED;
    k = ($urandom_range(0, 6) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE-1)];
    push_request(op, k, $urandom);
  endtask

  task automatic refresh_key_pool();
    int unsigned      i;
    int unsigned      j;
    bit               dup;
    logic [KEY_W-1:0] cand;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    for (i = 2; i < POOL_SIZE; i++) begin
      do begin
        // half of the keys cluster around zero so neighbors sit close together
        cand = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 200) - 100;
        dup = 1'b0;
        for (j = 0; j < i; j++) if (key_pool[j] == cand) dup = 1'b1;
      end while (dup);
      key_pool[i] = cand;
    end
  endtask

  // Walk the pool in shuffled order with one operation, with noise mixed in.
  task automatic walk_key_pool(input logic [FUNC_W-1:0] op, input int unsigned ins_w,
                               input int unsigned find_w, input int unsigned del_w);
    int unsigned order [POOL_SIZE];
    int unsigned i;
    int unsigned sel;
    int unsigned tmp;
    for (i = 0; i < POOL_SIZE; i++) order[i] = i;
    for (i = POOL_SIZE - 1; i > 0; i--) begin
      sel        = $urandom_range(0, i);
      tmp        = order[i];
      order[i]   = order[sel];
      order[sel] = tmp;
    end
    for (i = 0; i < POOL_SIZE; i++) begin
      push_request(op, key_pool[order[i]], $urandom);
      if ($urandom_range(0, 3) == 0) push_pool_op(ins_w, find_w, del_w);
    end
  endtask

  task automatic run_mixed(input int unsigned count, input int unsigned ins_w,
                           input int unsigned find_w, input int unsigned del_w);
    repeat (count) push_pool_op(ins_w, find_w, del_w);
  endtask

  // Receiver stall: switch between no stall, random stall and long stall runs.
  always @(posedge clk_i) begin
    if (stall_cycle % 64 == 0) stall_mode = stall_mode_e'($urandom_range(0, 2));
    stall_cycle++;
    case (stall_mode)
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_RANDOM: out_stall_i <= ($urandom_range(0, 2) == 0);
      default:      out_stall_i <= (stall_cycle % 16) < 11;
    endcase
  end

  always @(posedge clk_i) begin : check_results
    table_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d value_out %h",
               status_o, value_out_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        status_hits[want.status]++;
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (value_out_o !== want.value) begin
          $error("value_out: expected %h, got %h", want.value, value_out_o);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("sorted_key_value_table_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    table_result_t known;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = '0;
    key_i       = '0;
    value_i     = '0;
    out_stall_i = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      known.status = directed_rows[i].status;
      known.value  = directed_rows[i].value_out;
      push_request(directed_rows[i].func, directed_rows[i].key, directed_rows[i].value,
                   directed_rows[i].known, known);
    end
    wait_for_results();

    // fill past capacity, churn, drain, churn, then fill again
    refresh_key_pool();
    walk_key_pool(FUNC_INSERT, 40, 35, 20);
    wait_for_results();
    run_mixed(140, 40, 30, 25);
    wait_for_results();
    walk_key_pool(FUNC_DELETE, 10, 35, 50);
    wait_for_results();
    run_mixed(140, 45, 30, 20);
    wait_for_results();
    refresh_key_pool();
    walk_key_pool(FUNC_INSERT, 40, 35, 20);
    wait_for_results();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end

    $display("covered %0d requests and %0d results across directed, fill, churn and drain",
             requests_sent, results_checked);
    $display("inserted %0d, updated %0d, found %0d, not found %0d, deleted %0d, full %0d",
             status_hits[STS_INSERTED], status_hits[STS_UPDATED], status_hits[STS_FOUND],
             status_hits[STS_NOT_FOUND], status_hits[STS_DELETED], status_hits[STS_FULL]);
    if (error_count == 0) begin
      $display("sorted_key_value_table_top: match");
    end else begin
      $display("sorted_key_value_table_top: mismatch");
    end
    $finish;
  end

endmodule
